FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the percent codec RTL.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define UPC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that when ante holds, cons holds at the next clock edge.
`define UPC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/upc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upc_pkg
// Types, character constants and helper functions for the URI percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Escape scan phase
    localparam logic [1:0] PH_IDLE   = 2'd0;  // no escape pending
    localparam logic [1:0] PH_PCT    = 2'd1;  // '%' held
    localparam logic [1:0] PH_DIGIT  = 2'd2;  // '%' and one hex digit held
    localparam logic [1:0] PH_UNUSED = 2'd3;  // never held

    localparam int MAX_RES = 3;

    // One queued result byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } upc_entry_t;

    // Results of one input byte and the escape state it leaves
    typedef struct packed {
        logic [1:0]         count;
        logic [2:0][7:0]    res;
        logic [1:0]         phase;
        logic [7:0]         held;
    } upc_step_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Nibble value of a hex digit character; zero for anything else
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h57;
        hex_nib = v[3:0];
    endfunction

    // Upper-case hex digit character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            hex_char = 8'h30 + {4'h0, n};
        else
            hex_char = 8'h37 + {4'h0, n};
    endfunction

    function automatic logic is_safe(input logic [7:0] c);
        is_safe = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                  (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/upc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upc_step
// Combinational conversion of one input byte: results and next escape state.
// ----------------------------------------------------------------------------
module upc_step (
    input  wire logic              encode,
    input  wire logic [1:0]        phase,
    input  wire logic [7:0]        held,
    input  wire logic [7:0]        data_byte,
    input  wire logic              is_last,
    output upc_pkg::upc_step_t     step
);
    import upc_pkg::*;

    logic [2:0][7:0] q;
    logic [1:0]      cnt;
    logic [1:0]      ph;
    logic [7:0]      hd;

    always_comb
    begin
        q   = '0;
        cnt = 2'd0;
        ph  = phase;
        hd  = held;

        if (encode)
        begin
            if (is_safe(data_byte))
            begin
                q[0] = data_byte;
                cnt  = 2'd1;
            end
            else
            begin
                q[0] = PCT_CHAR;
                q[1] = hex_char(data_byte[7:4]);
                q[2] = hex_char(data_byte[3:0]);
                cnt  = 2'd3;
            end
            ph = PH_IDLE;
        end
        else
        begin
            case (phase)
                PH_PCT:
                begin
                    if (is_hex(data_byte))
                    begin
                        hd = data_byte;
                        ph = PH_DIGIT;
                    end
                    else
                    begin
                        // malformed escape: release the '%', rescan this byte
                        q[0] = PCT_CHAR;
                        cnt  = 2'd1;
                        if (data_byte == PCT_CHAR)
                            ph = PH_PCT;
                        else
                        begin
                            q[1] = data_byte;
                            cnt  = 2'd2;
                            ph   = PH_IDLE;
                        end
                    end
                end
                PH_DIGIT:
                begin
                    if (is_hex(data_byte))
                    begin
                        q[0] = {hex_nib(held), hex_nib(data_byte)};
                        cnt  = 2'd1;
                        ph   = PH_IDLE;
                    end
                    else
                    begin
                        q[0] = PCT_CHAR;
                        q[1] = held;
                        cnt  = 2'd2;
                        if (data_byte == PCT_CHAR)
                            ph = PH_PCT;
                        else
                        begin
                            q[2] = data_byte;
                            cnt  = 2'd3;
                            ph   = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    if (data_byte == PCT_CHAR)
                        ph = PH_PCT;
                    else
                    begin
                        q[0] = data_byte;
                        cnt  = 2'd1;
                        ph   = PH_IDLE;
                    end
                end
            endcase

            // flush whatever escape is still held at end of string
            if (is_last)
            begin
                if (ph == PH_PCT)
                begin
                    q[cnt] = PCT_CHAR;
                    cnt    = cnt + 2'd1;
                end
                else if (ph == PH_DIGIT)
                begin
                    q[cnt] = PCT_CHAR;
                    cnt    = cnt + 2'd1;
                    q[cnt] = hd;
                    cnt    = cnt + 2'd1;
                end
                ph = PH_IDLE;
            end
        end

        step.count = cnt;
        step.res   = q;
        step.phase = ph;
        step.held  = hd;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/uri_percent_codec_top.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// uri_percent_codec_top
// Streaming URI percent encoder/decoder with a four-entry result queue.
// ----------------------------------------------------------------------------
// Results: the result bytes of an input transfer are registered in the queue before they are offered.
// Throughput: one input byte per cycle while each yields at most one result
//   and res_ready stays high; results leave through a one-byte result port,
//   and the queue stops input while more than one byte waits.
// Reset: direction returns to decode, escape state and result queue clear.
module uri_percent_codec_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_data,
    input  wire logic       src_valid,
    output logic            src_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       is_last,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import upc_pkg::*;

    localparam int QDEPTH = 4;

    logic             dir_reg;
    logic [1:0]       phase_reg;
    logic [7:0]       held_reg;
    upc_entry_t       fifo_reg [QDEPTH];
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       rd_ptr_reg;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;

    upc_step_t        step;
    logic             accept;
    logic             last_xfer;
    logic             pop;
    logic [1:0]       push_n;

    upc_step u_step (
        .encode    (dir_reg),
        .phase     (phase_reg),
        .held      (held_reg),
        .data_byte (data_byte),
        .is_last   (is_last),
        .step      (step)
    );

    // room for a full three-byte expansion whenever at most one byte waits
    assign src_ready  = (count_reg <= 3'd1);
    assign accept     = src_valid && src_ready;
    assign last_xfer  = accept && is_last;
    assign res_valid  = (count_reg != 3'd0);
    assign pop        = res_valid && res_ready;
    assign push_n     = accept ? step.count : 2'd0;
    assign count_next = count_reg + {1'b0, push_n} - {2'b00, pop};

    assign out_byte = fifo_reg[rd_ptr_reg].data;
    assign out_last = fifo_reg[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= 1'b0;
            phase_reg  <= PH_IDLE;
            held_reg   <= 8'h00;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                // direction change drops any pending escape
                dir_reg   <= cfg_data;
                phase_reg <= PH_IDLE;
                held_reg  <= 8'h00;
            end
            else if (accept)
            begin
                phase_reg <= step.phase;
                held_reg  <= step.held;
            end
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (2'(i) < push_n)
            begin
                fifo_reg[wr_ptr_reg + 2'(i)].data <= step.res[i];
                fifo_reg[wr_ptr_reg + 2'(i)].last <= is_last && (2'(i) == push_n - 2'd1);
            end
        end
    end

    `UPC_ASSERT(a_count_max, count_reg <= 3'(QDEPTH), "result queue overfilled")
    `UPC_ASSERT(a_phase_valid, phase_reg != PH_UNUSED, "escape phase holds unused code")
    `UPC_ASSERT(a_last_yields, !last_xfer || step.count != 2'd0, "end of string gave no result")
    `UPC_ASSERT_NEXT(a_last_clears, last_xfer && !cfg_write, phase_reg == PH_IDLE, "escape open")
    `UPC_ASSERT_NEXT(a_count_track, 1'b1, count_reg == $past(count_next), "queue count slipped")

endmodule
`default_nettype wire

FILE: tb/upc_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// upc_stream_checker
// Watches the source, result and configuration ports of the URI percent
// codec, computes the converted bytes of every accepted source transfer and
// compares each result transfer with the oldest byte still expected.
// ----------------------------------------------------------------------------
module upc_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       src_valid,
    input  logic       src_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    output int         fail_count,
    output int         pending
);
    import upc_pkg::*;

    upc_entry_t expected_bytes[$];

    logic       encode_mode = 1'b0;
    logic [1:0] scan_phase  = PH_IDLE;
    logic [7:0] held_char   = 8'h00;
    logic [7:0] step_bytes[MAX_RES];
    int         step_count;
    int         err_total   = 0;
    int         pend_count  = 0;

    assign fail_count = err_total;
    assign pending    = pend_count;

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic bit url_safe(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0") + {4'h0, n};
        return 8'("A") + {4'h0, n} - 8'd10;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        if (step_count < MAX_RES)
        begin
            step_bytes[step_count] = b;
            step_count++;
        end
    endtask

    // Scan a byte with no escape open
    task automatic scan_plain(input logic [7:0] b);
        if (b == PCT_CHAR)
            scan_phase = PH_PCT;
        else
            emit_byte(b);
    endtask

    task automatic convert_byte(input logic [7:0] b, input logic last);
        int         lo;
        int         hi;
        upc_entry_t ent;
        step_count = 0;
        if (encode_mode)
        begin
            if (url_safe(b))
                emit_byte(b);
            else
            begin
                emit_byte(PCT_CHAR);
                emit_byte(nibble_char(b[7:4]));
                emit_byte(nibble_char(b[3:0]));
            end
            scan_phase = PH_IDLE;
        end
        else if (scan_phase == PH_PCT)
        begin
            if (digit_value(b) >= 0)
            begin
                held_char  = b;
                scan_phase = PH_DIGIT;
            end
            else
            begin
                // bad first digit: release the '%' and rescan this byte
                emit_byte(PCT_CHAR);
                scan_phase = PH_IDLE;
                scan_plain(b);
            end
        end
        else if (scan_phase == PH_DIGIT)
        begin
            lo = digit_value(b);
            if (lo >= 0)
            begin
                hi = digit_value(held_char);
                if (hi < 0)
                    hi = 0;
                emit_byte(8'(hi * 16 + lo));
                scan_phase = PH_IDLE;
            end
            else
            begin
                emit_byte(PCT_CHAR);
                emit_byte(held_char);
                scan_phase = PH_IDLE;
                scan_plain(b);
            end
        end
        else
        begin
            scan_phase = PH_IDLE;
            scan_plain(b);
        end

        // flush whatever escape is still open at end of string
        if (last)
        begin
            if (scan_phase == PH_PCT)
                emit_byte(PCT_CHAR);
            else if (scan_phase == PH_DIGIT)
            begin
                emit_byte(PCT_CHAR);
                emit_byte(held_char);
            end
            scan_phase = PH_IDLE;
        end

        for (int i = 0; i < step_count; i++)
        begin
            ent.data = step_bytes[i];
            ent.last = last && (i == step_count - 1);
            expected_bytes.push_back(ent);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        upc_entry_t exp_ent;
        if (!rst_n)
        begin
            encode_mode = 1'b0;
            scan_phase  = PH_IDLE;
            held_char   = 8'h00;
            expected_bytes.delete();
            pend_count <= 0;
        end
        else
        begin
            // check results first: a result never belongs to a same-edge input
            if (res_valid && res_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte %02h (out_last %0b) with no result expected",
                           out_byte, out_last);
                    err_total++;
                end
                else
                begin
                    exp_ent = expected_bytes.pop_front();
                    if (out_byte !== exp_ent.data)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               exp_ent.data, out_byte);
                        err_total++;
                    end
                    if (out_last !== exp_ent.last)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               exp_ent.last, out_last);
                        err_total++;
                    end
                end
            end

            if (cfg_write)
            begin
                encode_mode = cfg_data;
                scan_phase  = PH_IDLE;
                held_char   = 8'h00;
            end

            if (src_valid && src_ready)
                convert_byte(data_byte, is_last);

            pend_count <= expected_bytes.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the URI percent codec: directed strings for the
// escape corner cases in both directions, then random strings with random
// idle bursts on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic DIR_DECODE  = 1'b0;
    localparam logic DIR_ENCODE  = 1'b1;
    localparam int   LIMIT       = 200000;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN       = 4;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic       cfg_data;
    logic       src_valid;
    logic       src_ready;
    logic [7:0] data_byte;
    logic       is_last;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] out_byte;
    logic       out_last;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int random_sent   = 0;
    bit quiet         = 1'b0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;

    always #5 clk = ~clk;

    uri_percent_codec_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .data_byte (data_byte),
        .is_last   (is_last),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    upc_stream_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, none in the quiet tail
    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one byte and hold it until the transfer happens
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        src_valid <= 1'b1;
        data_byte <= b;
        is_last   <= last;
        do
            @(posedge clk);
        while (!src_ready);
    endtask

    task automatic send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], end_last && (i == s.len() - 1));
    endtask

    task automatic write_direction(input logic dir);
        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        // let a byte still in flight settle before the write
        repeat (DRAIN) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= dir;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0") + 8'(v);
        if ($urandom_range(0, 1) == 1)
            return 8'("A") + 8'(v - 10);
        return 8'("a") + 8'(v - 10);
    endfunction

    // Well-formed escapes with random content, plus broken ones, printable text and noise
    task automatic send_decode_string();
        logic [7:0] text[$];
        int         tokens;
        int         r;
        bit         end_last;
        tokens = $urandom_range(1, 5);
        for (int t = 0; t < tokens; t++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                text.push_back(8'($urandom_range(32, 126)));
            else if (r < 7)
            begin
                text.push_back(8'("%"));
                text.push_back(rand_hex_char());
                text.push_back(rand_hex_char());
            end
            else if (r == 7)
            begin
                text.push_back(8'("%"));
                text.push_back(8'($urandom_range(0, 255)));
            end
            else if (r == 8)
            begin
                text.push_back(8'("%"));
                text.push_back(rand_hex_char());
                text.push_back(8'($urandom_range(0, 255)));
            end
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
        end_last = ($urandom_range(0, 5) != 0);
        for (int i = 0; i < text.size(); i++)
        begin
            push_byte(text[i], end_last && (i == text.size() - 1));
            random_sent++;
        end
    endtask

    task automatic send_encode_string();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 1) == 1)
                push_byte(8'($urandom_range(0, 255)), i == len - 1);
            else
                push_byte(8'("a") + 8'($urandom_range(0, 25)), i == len - 1);
            random_sent++;
        end
    endtask

    initial
    begin
        logic dir;
        int   phase_goal;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = 1'b0;
        src_valid = 1'b0;
        data_byte = 8'h00;
        is_last   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // decode from reset: lower-case escape, decoded percent not rescanned,
        // bad first digit, percent reopening an escape, bad second digit
        send_text("%6a%2541%G%%4Z", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // end of string with a lone '%', then with '%' and one digit held
        send_text("%", 1'b1);
        send_text("%F", 1'b1);
        // direction write drops an open escape
        send_text("%4", 1'b0);
        write_direction(DIR_ENCODE);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        send_text("z-", 1'b1);

        dir = DIR_DECODE;
        for (int p = 0; p < 5; p++)
        begin
            write_direction(dir);
            phase_goal = random_sent + 36;
            while (random_sent < phase_goal)
            begin
                if (random_sent >= 70)
                    hold_off_req = 1'b1;
                if (random_sent >= 160)
                    quiet = 1'b1;
                if (dir == DIR_ENCODE)
                    send_encode_string();
                else
                    send_decode_string();
            end
            dir = ~dir;
        end
        // rewrite the same setting once
        write_direction(DIR_DECODE);
        send_text("%41", 1'b1);

        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (2 * DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
